>>> hw/rtl/bpbfs_pkg.sv
// Package for the best-fit buffer pool select unit.
// Sizes, status and command codes, and the scan tag that travels with each pool read.
// No dependencies.
package bpbfs_pkg;

   localparam int POOL_DEPTH   = 16;
   localparam int DIM_BITS     = 14;
   localparam int IDX_BITS     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_BITS     = $clog2(POOL_DEPTH + 1);
   localparam int AREA_BITS    = 2 * DIM_BITS;
   localparam int ENTRY_BITS   = 4;
   localparam int RELEASE_BITS = 4;
   localparam int STATUS_BITS  = 3;

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_REUSED      = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_APPENDED    = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_POOL_FULL   = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_RELEASED    = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_RELEASE_BAD = 3'd4;

   typedef struct packed {
      logic                live;
      logic                last;
      logic                free;
      logic [IDX_BITS-1:0] idx;
   } scan_tag_type;

endpackage

>>> hw/rtl/bpbfs_channels.sv
// Valid/ready channel interfaces for request and response words.
// Depends on bpbfs_pkg.
interface bpbfs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic [bpbfs_pkg::DIM_BITS-1:0]       req_width;
   logic [bpbfs_pkg::DIM_BITS-1:0]       req_height;
   logic [bpbfs_pkg::RELEASE_BITS-1:0]   release_index;

   modport source (output valid, cmd, req_width, req_height, release_index, input ready);
   modport sink   (input valid, cmd, req_width, req_height, release_index, output ready);
endinterface

interface bpbfs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [bpbfs_pkg::ENTRY_BITS-1:0]     entry_index;
   logic [bpbfs_pkg::STATUS_BITS-1:0]    status;

   modport source (output valid, entry_index, status, input ready);
   modport sink   (input valid, entry_index, status, output ready);
endinterface

>>> hw/rtl/bpbfs_store.sv
// Width/height memory of the pool: one write port, one registered read port.
// The scan tag is registered alongside the read data. Depends on bpbfs_pkg.
module bpbfs_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [bpbfs_pkg::IDX_BITS-1:0]  wr_addr,
   input  logic [bpbfs_pkg::DIM_BITS-1:0]  wr_width,
   input  logic [bpbfs_pkg::DIM_BITS-1:0]  wr_height,
   input  logic [bpbfs_pkg::IDX_BITS-1:0]  rd_addr,
   input  bpbfs_pkg::scan_tag_type         rd_tag,
   output bpbfs_pkg::scan_tag_type         out_tag,
   output logic [bpbfs_pkg::DIM_BITS-1:0]  out_width,
   output logic [bpbfs_pkg::DIM_BITS-1:0]  out_height
);

   logic [bpbfs_pkg::DIM_BITS-1:0] width_mem  [bpbfs_pkg::POOL_DEPTH];
   logic [bpbfs_pkg::DIM_BITS-1:0] height_mem [bpbfs_pkg::POOL_DEPTH];
   bpbfs_pkg::scan_tag_type        tag_ff;
   logic [bpbfs_pkg::DIM_BITS-1:0] width_ff;
   logic [bpbfs_pkg::DIM_BITS-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         width_mem[wr_addr]  <= wr_width;
         height_mem[wr_addr] <= wr_height;
      end
      width_ff  <= width_mem[rd_addr];
      height_ff <= height_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= rd_tag;
      end
   end

   assign out_tag    = tag_ff;
   assign out_width  = width_ff;
   assign out_height = height_ff;

endmodule

>>> hw/rtl/bpbfs_eval.sv
// Shared fit unit: size cover compare and area multiply for one entry per cycle.
// Results are registered with the scan tag. Depends on bpbfs_pkg.
module bpbfs_eval (
   input  logic                             clock,
   input  logic                             reset,
   input  bpbfs_pkg::scan_tag_type          in_tag,
   input  logic [bpbfs_pkg::DIM_BITS-1:0]   entry_width,
   input  logic [bpbfs_pkg::DIM_BITS-1:0]   entry_height,
   input  logic [bpbfs_pkg::DIM_BITS-1:0]   want_width,
   input  logic [bpbfs_pkg::DIM_BITS-1:0]   want_height,
   output bpbfs_pkg::scan_tag_type          out_tag,
   output logic                             out_covers,
   output logic [bpbfs_pkg::AREA_BITS-1:0]  out_area
);

   bpbfs_pkg::scan_tag_type         tag_ff;
   logic                            covers_ff;
   logic                            covers_in;
   logic [bpbfs_pkg::AREA_BITS-1:0] area_ff;
   logic [bpbfs_pkg::AREA_BITS-1:0] area_in;

   assign covers_in = (entry_width >= want_width) && (entry_height >= want_height);
   assign area_in   = bpbfs_pkg::AREA_BITS'(entry_width) * bpbfs_pkg::AREA_BITS'(entry_height);

   always_ff @(posedge clock) begin
      covers_ff <= covers_in;
      area_ff   <= area_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= in_tag;
      end
   end

   assign out_tag    = tag_ff;
   assign out_covers = covers_ff;
   assign out_area   = area_ff;

endmodule

>>> hw/rtl/buffer_pool_best_fit_select_unit.sv
// Best-fit buffer pool select unit: top level with the scan sequencer and pool state.
// A release is decided at accept, and its result passes through the result register into
// the output register. An acquire walks every pool entry once through the width/height memory
// read port and the shared fit unit, one entry per cycle, then decides and writes back
// before its response word is registered. The block takes one request at a time; a finished
// response waits in the output register while the next request is accepted.
// Depends on bpbfs_pkg, bpbfs_channels, bpbfs_store and bpbfs_eval.
module buffer_pool_best_fit_select_unit (
   input  logic         clock,
   input  logic         reset,
   bpbfs_req_if.sink    req_chan,
   bpbfs_rsp_if.source  rsp_chan
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam int DEPTH = bpbfs_pkg::POOL_DEPTH;
   localparam int IB    = bpbfs_pkg::IDX_BITS;
   localparam int CB    = bpbfs_pkg::CNT_BITS;
   localparam int DB    = bpbfs_pkg::DIM_BITS;
   localparam int AB    = bpbfs_pkg::AREA_BITS;
   localparam int EB    = bpbfs_pkg::ENTRY_BITS;
   localparam int SB    = bpbfs_pkg::STATUS_BITS;

   logic [2:0]       state_ff, state_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [DEPTH-1:0] busy_ff, busy_in;
   logic [CB-1:0]    count_ff, count_in;
   logic [IB-1:0]    ptr_ff, ptr_in;
   logic             have_ff, have_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [DB-1:0]    width_ff, width_in;
   logic [DB-1:0]    height_ff, height_in;
   logic [IB-1:0]    sel_ff, sel_in;
   logic             sel_cov_ff, sel_cov_in;
   logic [AB-1:0]    sel_area_ff, sel_area_in;
   logic [EB-1:0]    res_index_ff, res_index_in;
   logic [SB-1:0]    res_status_ff, res_status_in;
   logic [EB-1:0]    rsp_index_ff, rsp_index_in;
   logic [SB-1:0]    rsp_status_ff, rsp_status_in;

   bpbfs_pkg::scan_tag_type issue_tag;
   bpbfs_pkg::scan_tag_type mem_tag;
   bpbfs_pkg::scan_tag_type fit_tag;
   logic [DB-1:0]    mem_width, mem_height;
   logic             fit_covers;
   logic [AB-1:0]    fit_area;

   logic             wr_en;
   logic [IB-1:0]    wr_addr;
   logic             accept;
   logic             rel_in_range;
   logic [IB-1:0]    rel_idx;
   logic             rel_ok;
   logic             update;
   logic             rsp_load;
   logic             room;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.entry_index = rsp_index_ff;
   assign rsp_chan.status      = rsp_status_ff;

   assign rel_in_range = 32'(req_chan.release_index) < DEPTH;
   assign rel_idx      = IB'(req_chan.release_index);
   assign rel_ok       = rel_in_range && valid_ff[rel_idx] && busy_ff[rel_idx];
   assign room         = count_ff < CB'(DEPTH);

   assign issue_tag.live = (state_ff == ST_SCAN);
   assign issue_tag.last = (ptr_ff == IB'(DEPTH - 1));
   assign issue_tag.free = valid_ff[ptr_ff] && !busy_ff[ptr_ff];
   assign issue_tag.idx  = ptr_ff;

   assign update = fit_tag.live && fit_tag.free &&
                   (!have_ff || (fit_covers && (!sel_cov_ff || fit_area < sel_area_ff)));

   assign wr_en   = (state_ff == ST_FIN) && (have_ff || room);
   assign wr_addr = have_ff ? sel_ff : count_ff[IB-1:0];

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   bpbfs_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_width   (width_ff),
      .wr_height  (height_ff),
      .rd_addr    (ptr_ff),
      .rd_tag     (issue_tag),
      .out_tag    (mem_tag),
      .out_width  (mem_width),
      .out_height (mem_height)
   );

   bpbfs_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .in_tag       (mem_tag),
      .entry_width  (mem_width),
      .entry_height (mem_height),
      .want_width   (width_ff),
      .want_height  (height_ff),
      .out_tag      (fit_tag),
      .out_covers   (fit_covers),
      .out_area     (fit_area)
   );

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      busy_in       = busy_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      have_in       = have_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      sel_in        = sel_ff;
      sel_cov_in    = sel_cov_ff;
      sel_area_in   = sel_area_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;

      if (update) begin
         have_in     = 1'b1;
         sel_in      = fit_tag.idx;
         sel_cov_in  = fit_covers;
         sel_area_in = fit_area;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               width_in  = req_chan.req_width;
               height_in = req_chan.req_height;
               ptr_in    = '0;
               have_in   = 1'b0;
               if (req_chan.cmd == bpbfs_pkg::CMD_RELEASE) begin
                  res_index_in = req_chan.release_index;
                  if (rel_ok) begin
                     busy_in[rel_idx] = 1'b0;
                     res_status_in    = bpbfs_pkg::STATUS_RELEASED;
                  end else begin
                     res_status_in = bpbfs_pkg::STATUS_RELEASE_BAD;
                  end
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_tag.last) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + IB'(1);
            end
         end
         ST_DRAIN: begin
            if (fit_tag.live && fit_tag.last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (have_ff) begin
               busy_in[sel_ff] = 1'b1;
               res_index_in    = EB'(sel_ff);
               res_status_in   = bpbfs_pkg::STATUS_REUSED;
            end else if (room) begin
               valid_in[count_ff[IB-1:0]] = 1'b1;
               busy_in[count_ff[IB-1:0]]  = 1'b1;
               count_in                   = count_ff + CB'(1);
               res_index_in               = EB'(count_ff[IB-1:0]);
               res_status_in              = bpbfs_pkg::STATUS_APPENDED;
            end else begin
               res_index_in  = '0;
               res_status_in = bpbfs_pkg::STATUS_POOL_FULL;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_index_in  = rsp_load ? res_index_ff : rsp_index_ff;
   assign rsp_status_in = rsp_load ? res_status_ff : rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         busy_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff      <= width_in;
      height_ff     <= height_in;
      sel_ff        <= sel_in;
      sel_cov_ff    <= sel_cov_in;
      sel_area_ff   <= sel_area_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

>>> hw/rtl/bpbfs_check.sv
// Port-level checker for the best-fit buffer pool select unit, bound to the top level.
// Depends on bpbfs_pkg.
module bpbfs_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [bpbfs_pkg::ENTRY_BITS-1:0]    rsp_entry_index,
   input logic [bpbfs_pkg::STATUS_BITS-1:0]   rsp_status
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_index) && $stable(rsp_status))
      else $error("response word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= bpbfs_pkg::STATUS_RELEASE_BAD)
      else $error("undefined status code");

   a_full_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bpbfs_pkg::STATUS_POOL_FULL |-> rsp_entry_index == '0)
      else $error("pool full response with nonzero entry index");

endmodule

bind buffer_pool_best_fit_select_unit bpbfs_check u_bpbfs_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_entry_index (rsp_chan.entry_index),
   .rsp_status      (rsp_chan.status)
);
